FILE: rtl/lkvc_pkg.sv
package lkvc_pkg;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CAP_W = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_SET = 1'b1;

    // read value returned on a miss
    localparam logic [VAL_W-1:0] MISS_VALUE = {VAL_W{1'b1}};

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_UPDATE = 4'b1000
    } state_t;

endpackage

FILE: rtl/lru_key_value_cache_unit.sv
// channel   | transfer when              | signals
// ----------+----------------------------+------------------------------------
// request   | start && !busy             | cmd, lookup_key, store_value
// result    | done (one cycle, no stall) | hit, read_value
// capacity  | capacity_we                | capacity_wdata
//
// every request runs from one accepted start to the next as a scan with one key
// compare per cycle over the single read port of the key store, then a drain
// step and an update step for ranks, valid bits and stores.
// a get raises done in the cycle right after the update; a set gives no done.
// rst_n clears valid bits, ranks and the entry count at once; key and value
// stores are not cleared. the receiver cannot stall results.
module lru_key_value_cache_unit #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              cmd,
    input  logic signed [lkvc_pkg::KEY_W-1:0] lookup_key,
    input  logic signed [lkvc_pkg::VAL_W-1:0] store_value,
    output logic                              done,
    output logic                              hit,
    output logic signed [lkvc_pkg::VAL_W-1:0] read_value,
    input  logic                              capacity_we,
    input  logic        [lkvc_pkg::CAP_W-1:0] capacity_wdata
);

    // entry index, rank and count widths
    localparam int IW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int RW   = IW;
    localparam int CW   = $clog2(MAX_ENTRIES + 1);
    localparam int CMPW = ((CW > lkvc_pkg::CAP_W) ? CW : lkvc_pkg::CAP_W) + 1;

    lkvc_pkg::state_t state_reg, state_next;

    logic [lkvc_pkg::CAP_W-1:0] capacity_reg;

    // latched request
    logic                      cmd_reg;
    logic [lkvc_pkg::KEY_W-1:0] key_reg;
    logic [lkvc_pkg::VAL_W-1:0] val_in_reg;

    // key / value stores, one read port each, registered read
    logic [lkvc_pkg::KEY_W-1:0] key_mem [MAX_ENTRIES];
    logic [lkvc_pkg::VAL_W-1:0] val_mem [MAX_ENTRIES];
    logic [lkvc_pkg::KEY_W-1:0] key_rd_reg;
    logic [lkvc_pkg::VAL_W-1:0] val_rd_reg;

    // per entry state in flops
    logic [MAX_ENTRIES-1:0] valid_reg, valid_next;
    logic [RW-1:0]          rank_reg  [MAX_ENTRIES];
    logic [RW-1:0]          rank_next [MAX_ENTRIES];
    logic [CW-1:0]          count_reg, count_next;

    // scan sequencer
    logic [IW-1:0] scan_idx_reg;
    logic [IW-1:0] cmp_idx_reg;
    logic          cmp_vld_reg;

    // scan results
    logic                      found_reg;
    logic [IW-1:0]             hit_idx_reg;
    logic [RW-1:0]             hit_rank_reg;
    logic [lkvc_pkg::VAL_W-1:0] hit_val_reg;
    logic                      free_found_reg;
    logic [IW-1:0]             free_idx_reg;
    logic [IW-1:0]             old_idx_reg;

    // result registers
    logic                      done_reg;
    logic                      hit_reg;
    logic [lkvc_pkg::VAL_W-1:0] read_value_reg;

    logic          accept;
    logic          scan_last;
    logic          cmp_valid_entry;
    logic          key_match;
    logic          is_oldest;
    logic [CW:0]   rank_plus_one;
    logic [CMPW-1:0] cap_sat;
    logic          need_evict;
    logic          do_touch;
    logic          do_ins;
    logic          do_evict;
    logic          wr_key;
    logic          wr_val;
    logic [IW-1:0] slot_idx;
    logic [IW-1:0] wr_idx;

    assign accept    = start && (state_reg == lkvc_pkg::ST_IDLE);
    assign scan_last = (scan_idx_reg == IW'(MAX_ENTRIES - 1));

    // shared compare unit: one stored entry per cycle
    assign cmp_valid_entry = cmp_vld_reg && valid_reg[cmp_idx_reg];
    assign key_match       = cmp_valid_entry && (key_rd_reg == key_reg);
    assign rank_plus_one   = (CW + 1)'(rank_reg[cmp_idx_reg]) + (CW + 1)'(1);
    assign is_oldest       = cmp_valid_entry && (rank_plus_one == (CW + 1)'(count_reg));

    // capacity saturates at the store depth
    assign cap_sat = (CMPW'(capacity_reg) > CMPW'(MAX_ENTRIES)) ?
                     CMPW'(MAX_ENTRIES) : CMPW'(capacity_reg);
    assign need_evict = (CMPW'(count_reg) + CMPW'(1)) > cap_sat;

    assign do_touch = (cmd_reg == lkvc_pkg::CMD_GET) && found_reg;
    // insert of a new key, dropped when nothing may be kept
    assign do_ins   = (cmd_reg == lkvc_pkg::CMD_SET) && !found_reg &&
                      !(need_evict && (count_reg == '0));
    assign do_evict = do_ins && need_evict;

    // first free slot once the oldest entry is gone
    assign slot_idx = (do_evict && (!free_found_reg || (old_idx_reg < free_idx_reg))) ?
                      old_idx_reg : free_idx_reg;

    assign wr_key = (state_reg == lkvc_pkg::ST_UPDATE) && do_ins;
    assign wr_val = (state_reg == lkvc_pkg::ST_UPDATE) &&
                    (do_ins || ((cmd_reg == lkvc_pkg::CMD_SET) && found_reg));
    assign wr_idx = do_ins ? slot_idx : hit_idx_reg;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lkvc_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = lkvc_pkg::ST_SCAN;
                end
            end
            lkvc_pkg::ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = lkvc_pkg::ST_DRAIN;
                end
            end
            lkvc_pkg::ST_DRAIN:
            begin
                state_next = lkvc_pkg::ST_UPDATE;
            end
            lkvc_pkg::ST_UPDATE:
            begin
                state_next = lkvc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = lkvc_pkg::ST_IDLE;
            end
        endcase
    end

    // rank, valid and count update, each entry on its own
    always_comb
    begin
        valid_next = valid_reg;
        count_next = count_reg;
        for (int j = 0; j < MAX_ENTRIES; j++)
        begin
            rank_next[j] = rank_reg[j];
        end
        if (state_reg == lkvc_pkg::ST_UPDATE)
        begin
            if (do_touch)
            begin
                for (int j = 0; j < MAX_ENTRIES; j++)
                begin
                    if (IW'(j) == hit_idx_reg)
                    begin
                        rank_next[j] = '0;
                    end
                    else if (valid_reg[j] && (rank_reg[j] < hit_rank_reg))
                    begin
                        rank_next[j] = rank_reg[j] + RW'(1);
                    end
                end
            end
            else if (do_ins)
            begin
                for (int j = 0; j < MAX_ENTRIES; j++)
                begin
                    priority if (IW'(j) == slot_idx)
                    begin
                        valid_next[j] = 1'b1;
                        rank_next[j]  = '0;
                    end
                    else if (do_evict && (IW'(j) == old_idx_reg))
                    begin
                        valid_next[j] = 1'b0;
                        rank_next[j]  = '0;
                    end
                    else if (valid_reg[j])
                    begin
                        rank_next[j] = rank_reg[j] + RW'(1);
                    end
                end
                count_next = do_evict ? count_reg : (count_reg + CW'(1));
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= lkvc_pkg::ST_IDLE;
            capacity_reg   <= lkvc_pkg::CAP_RESET;
            valid_reg      <= '0;
            count_reg      <= '0;
            scan_idx_reg   <= '0;
            cmp_vld_reg    <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            done_reg       <= 1'b0;
            for (int j = 0; j < MAX_ENTRIES; j++)
            begin
                rank_reg[j] <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            count_reg   <= count_next;
            cmp_vld_reg <= (state_reg == lkvc_pkg::ST_SCAN);
            for (int j = 0; j < MAX_ENTRIES; j++)
            begin
                rank_reg[j] <= rank_next[j];
            end
            if (capacity_we)
            begin
                capacity_reg <= capacity_wdata;
            end
            if (accept)
            begin
                scan_idx_reg   <= '0;
                found_reg      <= 1'b0;
                free_found_reg <= 1'b0;
            end
            else if (state_reg == lkvc_pkg::ST_SCAN)
            begin
                scan_idx_reg <= scan_idx_reg + IW'(1);
            end
            // first match and first free slot win
            if (key_match && !found_reg)
            begin
                found_reg <= 1'b1;
            end
            if (cmp_vld_reg && !valid_reg[cmp_idx_reg] && !free_found_reg)
            begin
                free_found_reg <= 1'b1;
            end
            done_reg <= (state_reg == lkvc_pkg::ST_UPDATE) && (cmd_reg == lkvc_pkg::CMD_GET);
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= cmd;
            key_reg    <= lookup_key;
            val_in_reg <= store_value;
        end
        cmp_idx_reg <= scan_idx_reg;
        if (key_match && !found_reg)
        begin
            hit_idx_reg  <= cmp_idx_reg;
            hit_rank_reg <= rank_reg[cmp_idx_reg];
            hit_val_reg  <= val_rd_reg;
        end
        if (cmp_vld_reg && !valid_reg[cmp_idx_reg] && !free_found_reg)
        begin
            free_idx_reg <= cmp_idx_reg;
        end
        if (is_oldest)
        begin
            old_idx_reg <= cmp_idx_reg;
        end
        if (state_reg == lkvc_pkg::ST_UPDATE)
        begin
            hit_reg        <= found_reg;
            read_value_reg <= found_reg ? hit_val_reg : lkvc_pkg::MISS_VALUE;
        end
    end

    // key and value stores
    always_ff @(posedge clk)
    begin
        if (wr_key)
        begin
            key_mem[wr_idx] <= key_reg;
        end
        if (state_reg == lkvc_pkg::ST_SCAN)
        begin
            key_rd_reg <= key_mem[scan_idx_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_val)
        begin
            val_mem[wr_idx] <= val_in_reg;
        end
        if (state_reg == lkvc_pkg::ST_SCAN)
        begin
            val_rd_reg <= val_mem[scan_idx_reg];
        end
    end

    assign busy       = (state_reg != lkvc_pkg::ST_IDLE);
    assign done       = done_reg;
    assign hit        = hit_reg;
    assign read_value = read_value_reg;

`ifndef ASSERT_OFF
    // entry count tracks the valid bits
    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == 32'(count_reg))
        else $error("entry count differs from number of valid entries");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= MAX_ENTRIES)
        else $error("entry count above store depth");

    // results only come out of the update step
    a_done_after_update: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == lkvc_pkg::ST_UPDATE))
        else $error("result strobe without update step");

    a_miss_value: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !hit) |-> (read_value == lkvc_pkg::MISS_VALUE))
        else $error("miss result without all-ones value");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("not busy after accepted request");
`endif

endmodule

FILE: tb/lkvc_checker.sv
module lkvc_checker #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  logic                              cmd,
    input  logic signed [lkvc_pkg::KEY_W-1:0] lookup_key,
    input  logic signed [lkvc_pkg::VAL_W-1:0] store_value,
    input  logic                              done,
    input  logic                              hit,
    input  logic signed [lkvc_pkg::VAL_W-1:0] read_value,
    input  logic                              capacity_we,
    input  logic        [lkvc_pkg::CAP_W-1:0] capacity_wdata,
    output int                                fail_count,
    output int                                outstanding,
    output int                                lookups_checked,
    output int                                hits_seen
);

    typedef struct packed {
        logic                       hit;
        logic [lkvc_pkg::VAL_W-1:0] value;
    } lookup_result_t;

    // shadow copy of the cache
    logic [lkvc_pkg::KEY_W-1:0] key_store [MAX_ENTRIES];
    logic [lkvc_pkg::VAL_W-1:0] val_store [MAX_ENTRIES];
    bit                         slot_used [MAX_ENTRIES];
    int unsigned                age       [MAX_ENTRIES];
    int unsigned                used_count;
    logic [lkvc_pkg::CAP_W-1:0] cap_reg;

    lookup_result_t lookup_q[$];
    int errors;
    int checked;
    int hits;

    function automatic int find_slot(input logic [lkvc_pkg::KEY_W-1:0] k);
        for (int i = 0; i < MAX_ENTRIES; i++)
            if (slot_used[i] && key_store[i] == k)
                return i;
        return -1;
    endfunction

    function automatic void evict_oldest();
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            if (slot_used[i] && age[i] + 1 == used_count)
            begin
                slot_used[i] = 1'b0;
                age[i] = 0;
                used_count--;
                return;
            end
        end
    endfunction

    function automatic void insert_entry(input logic [lkvc_pkg::KEY_W-1:0] k,
                                         input logic [lkvc_pkg::VAL_W-1:0] v);
        int unsigned limit;
        int free_slot;
        limit = (cap_reg > MAX_ENTRIES) ? MAX_ENTRIES : cap_reg;
        free_slot = -1;
        if (used_count + 1 > limit)
        begin
            // zero capacity with nothing held: the insert is dropped
            if (used_count == 0)
                return;
            evict_oldest();
        end
        for (int i = MAX_ENTRIES - 1; i >= 0; i--)
            if (!slot_used[i])
                free_slot = i;
        if (free_slot < 0)
            return;
        for (int i = 0; i < MAX_ENTRIES; i++)
            if (slot_used[i])
                age[i]++;
        slot_used[free_slot] = 1'b1;
        key_store[free_slot] = k;
        val_store[free_slot] = v;
        age[free_slot] = 0;
        used_count++;
    endfunction

    function automatic void predict_request(input logic c,
                                            input logic [lkvc_pkg::KEY_W-1:0] k,
                                            input logic [lkvc_pkg::VAL_W-1:0] v);
        int idx;
        int unsigned r;
        lookup_result_t res;
        idx = find_slot(k);
        if (c == lkvc_pkg::CMD_SET)
        begin
            if (idx >= 0)
                val_store[idx] = v;
            else
                insert_entry(k, v);
            return;
        end
        if (idx >= 0)
        begin
            r = age[idx];
            for (int i = 0; i < MAX_ENTRIES; i++)
                if (slot_used[i] && age[i] < r)
                    age[i]++;
            age[idx] = 0;
            res.hit = 1'b1;
            res.value = val_store[idx];
        end
        else
        begin
            res.hit = 1'b0;
            res.value = lkvc_pkg::MISS_VALUE;
        end
        lookup_q.push_back(res);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        lookup_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                slot_used[i] = 1'b0;
                age[i] = 0;
            end
            used_count = 0;
            cap_reg = lkvc_pkg::CAP_RESET;
            lookup_q.delete();
            errors = 0;
            checked = 0;
            hits = 0;
        end
        else
        begin
            // older lookup result first, then any new transfer
            if (done)
            begin
                if (lookup_q.size() == 0)
                begin
                    $error("result transfer with no lookup pending: hit %0b read_value %h",
                           hit, read_value);
                    errors++;
                end
                else
                begin
                    want = lookup_q.pop_front();
                    checked++;
                    if (hit !== want.hit)
                    begin
                        $error("hit mismatch: expected %0b, actual %0b", want.hit, hit);
                        errors++;
                    end
                    if (read_value !== want.value)
                    begin
                        $error("read_value mismatch: expected %h, actual %h",
                               want.value, read_value);
                        errors++;
                    end
                    if (want.hit)
                        hits++;
                end
            end
            if (capacity_we)
                cap_reg = capacity_wdata;
            if (start && !busy)
                predict_request(cmd, lookup_key, store_value);
        end
        fail_count      <= errors;
        outstanding     <= lookup_q.size();
        lookups_checked <= checked;
        hits_seen       <= hits;
    end

endmodule

FILE: tb/tb_lru_key_value_cache_unit.sv
module tb_lru_key_value_cache_unit;

    localparam int CLK_PERIOD     = 20;
    localparam int MAX_ENTRIES    = 16;
    // one full request time, waited out at the end of each drain
    localparam int REQ_CYCLES     = MAX_ENTRIES + 3;
    localparam int DRAIN_LIMIT    = 20 * REQ_CYCLES;
    localparam int TIMEOUT_CYCLES = 500000;

    // every block input has a known value from time zero
    logic                         clk            = 1'b0;
    logic                         rst_n          = 1'b0;
    logic                         start          = 1'b0;
    logic                         cmd            = lkvc_pkg::CMD_GET;
    logic signed [31:0]           lookup_key     = '0;
    logic signed [31:0]           store_value    = '0;
    logic                         capacity_we    = 1'b0;
    logic [lkvc_pkg::CAP_W-1:0]   capacity_wdata = lkvc_pkg::CAP_RESET;
    logic                         busy;
    logic                         done;
    logic                         hit;
    logic signed [31:0]           read_value;

    int fail_count;
    int outstanding;
    int lookups_checked;
    int hits_seen;

    // stimulus bookkeeping for the summary
    int gets_sent;
    int sets_sent;
    int cap_writes;
    bit stalled;
    bit idle_on;

    // key pool for the random part, so that gets mostly hit recent sets
    logic [31:0] key_pool [32];
    int          pool_size;

    lru_key_value_cache_unit #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .cmd            (cmd),
        .lookup_key     (lookup_key),
        .store_value    (store_value),
        .done           (done),
        .hit            (hit),
        .read_value     (read_value),
        .capacity_we    (capacity_we),
        .capacity_wdata (capacity_wdata)
    );

    // watches the request, result and capacity channels, predicts and compares
    lkvc_checker #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .cmd             (cmd),
        .lookup_key      (lookup_key),
        .store_value     (store_value),
        .done            (done),
        .hit             (hit),
        .read_value      (read_value),
        .capacity_we     (capacity_we),
        .capacity_wdata  (capacity_wdata),
        .fail_count      (fail_count),
        .outstanding     (outstanding),
        .lookups_checked (lookups_checked),
        .hits_seen       (hits_seen)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // hard stop in case the block hangs
    initial
    begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("CHECKS FAILED");
        $finish;
    end

    // one of the four corner patterns of a 32-bit field
    function automatic logic [31:0] corner_word();
        case ($urandom_range(0, 3))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            default: return 32'h7FFF_FFFF;
        endcase
    endfunction

    // idle cycles before a request: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 4);
        if (r < 97)
            return $urandom_range(5, 25);
        return $urandom_range(26, 60);
    endfunction

    // one request transfer; called at a rising edge, returns at the accepting edge
    // with start still high, so back-to-back requests need no extra edge
    task automatic send_request(input logic c, input logic [31:0] k, input logic [31:0] v,
                                input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start       <= 1'b1;
        cmd         <= c;
        lookup_key  <= k;
        store_value <= v;
        // busy is sampled before the block's own update at this edge
        do @(posedge clk); while (busy);
        if (c == lkvc_pkg::CMD_SET)
            sets_sent++;
        else
            gets_sent++;
    endtask

    // stop sending and wait until every lookup result is back and the block is idle;
    // a trailing set gives no result, so also wait out one full request time
    task automatic drain_requests();
        int waited = 0;
        start <= 1'b0;
        @(posedge clk);
        while ((outstanding != 0 || busy) && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (waited >= DRAIN_LIMIT)
        begin
            $error("lookup results still pending after %0d cycles", waited);
            stalled = 1'b1;
        end
        repeat (REQ_CYCLES) @(posedge clk);
    endtask

    // capacity is only written while the block is idle
    task automatic write_capacity(input logic [lkvc_pkg::CAP_W-1:0] c);
        drain_requests();
        capacity_we    <= 1'b1;
        capacity_wdata <= c;
        @(posedge clk);
        capacity_we    <= 1'b0;
        cap_writes++;
    endtask

    // fresh key pool sized around the effective capacity so evictions keep happening
    task automatic build_pool(input logic [lkvc_pkg::CAP_W-1:0] c);
        int eff;
        int r;
        eff = (c > MAX_ENTRIES) ? MAX_ENTRIES : c;
        pool_size = eff + $urandom_range(1, 8);
        if (pool_size > 32)
            pool_size = 32;
        for (int i = 0; i < pool_size; i++)
        begin
            r = $urandom_range(0, 9);
            if (r == 0)
                key_pool[i] = corner_word();
            else if (r == 1 && i > 0)
                // one bit away from another key, exercises the raw compare
                key_pool[i] = key_pool[0] ^ (32'h1 << $urandom_range(0, 31));
            else
                key_pool[i] = $urandom;
        end
    endtask

    // random traffic at one capacity setting
    task automatic run_phase(input logic [lkvc_pkg::CAP_W-1:0] c, input int n_items,
                             input bit idling);
        logic        c_cmd;
        logic [31:0] k;
        logic [31:0] v;
        write_capacity(c);
        build_pool(c);
        idle_on = idling;
        for (int n = 0; n < n_items; n++)
        begin
            c_cmd = $urandom_range(0, 1) ? lkvc_pkg::CMD_SET : lkvc_pkg::CMD_GET;
            // mostly pool keys, some noise keys that nearly always miss
            if ($urandom_range(0, 9) == 0)
                k = $urandom;
            else
                k = key_pool[$urandom_range(0, pool_size - 1)];
            if ($urandom_range(0, 9) == 0)
                v = corner_word();
            else
                v = $urandom;
            send_request(c_cmd, k, v, pick_gap());
        end
    endtask

    initial
    begin
        logic [lkvc_pkg::CAP_W-1:0] c;
        gets_sent  = 0;
        sets_sent  = 0;
        cap_writes = 0;
        stalled    = 1'b0;
        idle_on    = 1'b1;

        // reset once, then released
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed part ---
        // zero capacity on an empty store: the insert is dropped
        write_capacity(5'd0);
        send_request(lkvc_pkg::CMD_SET, 32'd5, 32'h0000_1234, 0);
        send_request(lkvc_pkg::CMD_GET, 32'd5, 32'hFFFF_FFFF, 2);

        // full capacity, corner keys and values
        write_capacity(lkvc_pkg::CAP_RESET);
        send_request(lkvc_pkg::CMD_GET, 32'h0000_0000, 32'h0000_0000, 0);
        send_request(lkvc_pkg::CMD_SET, 32'h8000_0000, 32'h7FFF_FFFF, 0);
        send_request(lkvc_pkg::CMD_SET, 32'h7FFF_FFFF, 32'h8000_0000, 1);
        send_request(lkvc_pkg::CMD_SET, 32'h0000_0000, 32'h0000_0000, 0);
        send_request(lkvc_pkg::CMD_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3);
        send_request(lkvc_pkg::CMD_GET, 32'h8000_0000, 32'h0000_0000, 0);
        send_request(lkvc_pkg::CMD_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0);
        send_request(lkvc_pkg::CMD_GET, 32'h0000_0000, 32'h5555_5555, 7);
        // hit that returns all ones, told apart from a miss only by hit
        send_request(lkvc_pkg::CMD_GET, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 0);
        // overwrite in place leaves recency as it is
        send_request(lkvc_pkg::CMD_SET, 32'h0000_0000, 32'hA5A5_A5A5, 0);
        send_request(lkvc_pkg::CMD_GET, 32'h0000_0000, 32'h0000_0000, 0);
        // one bit off a stored key is a miss
        send_request(lkvc_pkg::CMD_GET, 32'h8000_0001, 32'h0000_0000, 0);

        // capacity lowered below the count: entries stay, each insert evicts one
        write_capacity(5'd2);
        send_request(lkvc_pkg::CMD_SET, 32'd100, 32'h0BAD_F00D, 0);
        send_request(lkvc_pkg::CMD_GET, 32'h8000_0000, 32'h0000_0000, 0);
        send_request(lkvc_pkg::CMD_GET, 32'd100, 32'h0000_0000, 0);

        // zero capacity on a non-empty store: evict least recent, keep new one
        write_capacity(5'd0);
        send_request(lkvc_pkg::CMD_SET, 32'd200, 32'hDEAD_BEEF, 0);
        send_request(lkvc_pkg::CMD_GET, 32'd200, 32'h0000_0000, 0);
        send_request(lkvc_pkg::CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000, 0);

        // --- random part ---
        // corner capacities first, including saturated values above the depth
        run_phase(5'd31, 80, 1'b1);
        run_phase(5'd1,  60, 1'b1);
        run_phase(lkvc_pkg::CAP_RESET, 80, 1'b0);
        run_phase(5'd0,  40, 1'b1);
        run_phase(5'd17, 70, 1'b1);
        run_phase(5'd4,  60, 1'b0);
        for (int p = 0; p < 5; p++)
        begin
            c = lkvc_pkg::CAP_W'($urandom_range(0, 31));
            run_phase(c, 60, 1'b1);
        end

        // wait for the last results and a full request time beyond
        drain_requests();

        $display("covered %0d gets and %0d sets over %0d capacity writes", gets_sent,
                 sets_sent, cap_writes);
        $display("checked %0d lookup results, %0d of them hits", lookups_checked, hits_seen);
        if (fail_count == 0 && !stalled && outstanding == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
